// File: hw/rtl/serial_api_frame_receiver_unit_assert.svh
// ----------------------------------------------------------------------------
// Serial API frame receiver assertion macros
// Concurrent assertion helpers clocked by aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_API_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define SERIAL_API_FRAME_RECEIVER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SAPFR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define SAPFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SAPFR_ASSERT_IMPL(lbl, ante, cons, msg)
`define SAPFR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hw/rtl/sapfr_pkg.sv
// ----------------------------------------------------------------------------
// Serial API frame receiver package
// Shared constants, item and result types for the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sapfr_pkg;

    localparam int SAPFR_BUFFER_DEPTH = 512;
    localparam int HOME_ID_BYTES      = 4;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1500;

    // Protocol bytes.
    localparam logic [7:0] SOF_BYTE    = 8'h01;
    localparam logic [7:0] ACK_BYTE    = 8'h06;
    localparam logic [7:0] NAK_BYTE    = 8'h15;
    localparam logic [7:0] CAN_BYTE    = 8'h18;
    localparam logic [7:0] MENU_BYTE   = 8'h0D;
    localparam logic [7:0] UPLOAD_BYTE = 8'h43;
    localparam logic [7:0] MIN_LEN        = 8'd3;
    localparam logic [7:0] MIN_HOMEID_LEN = 8'd7;
    localparam logic [7:0] RESP_TYPE      = 8'h01;
    localparam logic [7:0] NETIDS_CMD     = 8'h20;
    localparam logic [7:0] XOR_INIT       = 8'hFF;

    // Action codes on the input channel.
    localparam logic [2:0] ACT_BYTE   = 3'd0;
    localparam logic [2:0] ACT_TICK   = 3'd1;
    localparam logic [2:0] ACT_READ   = 3'd2;
    localparam logic [2:0] ACT_DISC   = 3'd3;
    localparam logic [2:0] ACT_RECONN = 3'd4;

    // Event codes on the result channel.
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_FWD     = 3'd1;
    localparam logic [2:0] EV_FRAME   = 3'd2;
    localparam logic [2:0] EV_MENU    = 3'd3;
    localparam logic [2:0] EV_REJECT  = 3'd4;
    localparam logic [2:0] EV_TIMEOUT = 3'd5;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_BYTE,
        KIND_TICK,
        KIND_READ,
        KIND_DISC,
        KIND_RECONN
    } kind_t;

    typedef struct packed {
        logic is_sof;
        logic is_menu;
        logic is_fwd;
        logic is_menu_char;
        logic is_nul;
    } byte_class_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  rx_byte;
        logic [8:0]  read_index;
        byte_class_t cls;
    } sapfr_item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [2:0]  event_res;
        logic [7:0]  event_byte;
        logic [9:0]  frame_length;
        logic [31:0] home_id;
        logic        home_id_changed;
        logic        home_id_ready;
        logic        bootloader_mode;
        logic        read_hit;
    } sapfr_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/sapfr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sapfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sapfr_front.sv
// ----------------------------------------------------------------------------
// Frame receiver front end
// Accepts items, decodes the action and classifies the byte into a queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sapfr_front
    import sapfr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_action,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic [8:0]  s_read_index,
    output logic             q_valid,
    input  wire logic        q_pop,
    output sapfr_item_t      q_item
);

    sapfr_item_t fifo_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    sapfr_item_t item;
    logic        push, pop;

    always_comb begin
        item            = '0;
        item.rx_byte    = s_rx_byte;
        item.read_index = s_read_index;
        case (s_action)
            ACT_BYTE:   item.kind = KIND_BYTE;
            ACT_TICK:   item.kind = KIND_TICK;
            ACT_READ:   item.kind = KIND_READ;
            ACT_DISC:   item.kind = KIND_DISC;
            ACT_RECONN: item.kind = KIND_RECONN;
            default:    item.kind = KIND_NONE;
        endcase
        item.cls.is_sof  = (s_rx_byte == SOF_BYTE);
        item.cls.is_menu = (s_rx_byte == MENU_BYTE);
        item.cls.is_fwd  = s_rx_byte inside {ACK_BYTE, NAK_BYTE, CAN_BYTE, UPLOAD_BYTE};
        item.cls.is_menu_char = s_rx_byte inside {8'h00, 8'h0D, 8'h0A, [8'h20:8'h7E]};
        item.cls.is_nul  = (s_rx_byte == 8'h00);
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = fifo_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_pop;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sapfr_back.sv
// ----------------------------------------------------------------------------
// Frame receiver back end
// Runs the parser, owns the frame store and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sapfr_back
    import sapfr_pkg::*;
#(
    parameter int BUFFER_DEPTH = SAPFR_BUFFER_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [15:0] timeout_ms,
    input  wire logic        q_valid,
    output logic             q_pop,
    input  wire sapfr_item_t q_item,
    output logic             m_valid,
    input  wire logic        m_ready,
    output sapfr_result_t    m_res,
    output logic [7:0]       m_read_data
);

    localparam int AW       = $clog2(BUFFER_DEPTH);
    localparam int WPW      = $clog2(BUFFER_DEPTH + 1);
    localparam int HDR_LAST = 3 + HOME_ID_BYTES;

    typedef enum logic [6:0] {
        PH_START   = 7'b0000001,
        PH_LENGTH  = 7'b0000010,
        PH_TYPE    = 7'b0000100,
        PH_CMD     = 7'b0001000,
        PH_PAYLOAD = 7'b0010000,
        PH_CHECK   = 7'b0100000,
        PH_MENU    = 7'b1000000
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [WPW-1:0]  wpos_reg, wpos_next;
    logic [8:0]      endpos_reg, endpos_next;
    logic [7:0]      xor_reg, xor_next;
    logic            boot_reg, boot_next;
    logic [31:0]     hid_reg, hid_next;
    logic            have_reg, have_next;
    logic [15:0]     ms_reg, ms_next;
    logic [7:0]      hdr_reg [1:HDR_LAST];
    logic            m_valid_reg;
    sapfr_result_t   res_reg, res;

    logic            exec;
    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_q;
    logic [7:0]      b;
    logic [WPW-1:0]  wpos_inc;
    logic            wpos_fits;
    logic [31:0]     id;

    // Start-byte handling shared by the idle phase and a dropped menu.
    phase_t          st_phase;
    logic [WPW-1:0]  st_wpos;
    logic            st_write, st_boot;
    logic [15:0]     st_ms;
    logic [2:0]      st_ev;

    assign exec  = q_valid && (!m_valid_reg || m_ready);
    assign q_pop = exec;
    assign b     = q_item.rx_byte;

    always_comb begin
        st_phase = PH_START;
        st_wpos  = '0;
        st_write = 1'b0;
        st_boot  = boot_reg;
        st_ms    = ms_reg;
        st_ev    = EV_NONE;
        if (q_item.cls.is_sof) begin
            st_phase = PH_LENGTH;
            st_wpos  = WPW'(1);
            st_write = 1'b1;
            st_boot  = 1'b0;
            st_ms    = '0;
        end else if (q_item.cls.is_menu) begin
            st_phase = PH_MENU;
            st_wpos  = WPW'(1);
            st_write = 1'b1;
            st_ms    = '0;
        end else if (q_item.cls.is_fwd) begin
            st_ev = EV_FWD;
        end
    end

    always_comb begin
        id = '0;
        for (int i = 0; i < HOME_ID_BYTES; i++) begin
            id = {id[23:0], hdr_reg[4 + i]};
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        wpos_next   = wpos_reg;
        endpos_next = endpos_reg;
        xor_next    = xor_reg;
        boot_next   = boot_reg;
        hid_next    = hid_reg;
        have_next   = have_reg;
        ms_next     = ms_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = AW'(wpos_reg);
        res         = '0;
        wpos_inc    = wpos_reg + WPW'(1);
        wpos_fits   = (wpos_reg < WPW'(BUFFER_DEPTH));

        case (q_item.kind)
            KIND_BYTE: begin
                case (phase_reg)
                    PH_START: begin
                        phase_next    = st_phase;
                        wpos_next     = st_wpos;
                        boot_next     = st_boot;
                        ms_next       = st_ms;
                        ram_we        = st_write;
                        ram_waddr     = '0;
                        res.event_res = st_ev;
                    end
                    PH_LENGTH: begin
                        if (b < MIN_LEN) begin
                            phase_next    = PH_START;
                            res.tx_valid  = 1'b1;
                            res.tx_byte   = NAK_BYTE;
                            res.event_res = EV_REJECT;
                        end else begin
                            endpos_next = 9'(wpos_reg) + {1'b0, b};
                            xor_next    = XOR_INIT ^ b;
                            ram_we      = wpos_fits;
                            wpos_next   = wpos_inc;
                            phase_next  = PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        xor_next   = xor_reg ^ b;
                        ram_we     = wpos_fits;
                        wpos_next  = wpos_inc;
                        phase_next = PH_CMD;
                    end
                    PH_CMD, PH_PAYLOAD: begin
                        xor_next   = xor_reg ^ b;
                        ram_we     = wpos_fits;
                        wpos_next  = wpos_inc;
                        phase_next = (wpos_inc >= WPW'(endpos_reg)) ? PH_CHECK : PH_PAYLOAD;
                    end
                    PH_CHECK: begin
                        ram_we       = wpos_fits;
                        wpos_next    = wpos_inc;
                        phase_next   = PH_START;
                        res.tx_valid = 1'b1;
                        if (xor_reg != b) begin
                            res.tx_byte   = NAK_BYTE;
                            res.event_res = EV_REJECT;
                        end else begin
                            res.tx_byte      = ACK_BYTE;
                            res.event_res    = EV_FRAME;
                            res.frame_length = 10'(wpos_inc);
                            if (!boot_reg && hdr_reg[1] >= MIN_HOMEID_LEN &&
                                hdr_reg[2] == RESP_TYPE && hdr_reg[3] == NETIDS_CMD) begin
                                hid_next            = id;
                                res.home_id_changed = (id != hid_reg);
                                have_next           = 1'b1;
                            end
                        end
                    end
                    PH_MENU: begin
                        if (!wpos_fits || !q_item.cls.is_menu_char) begin
                            phase_next    = st_phase;
                            wpos_next     = st_wpos;
                            boot_next     = st_boot;
                            ms_next       = st_ms;
                            ram_we        = st_write;
                            ram_waddr     = '0;
                            res.event_res = st_ev;
                        end else begin
                            ram_we    = 1'b1;
                            wpos_next = wpos_inc;
                            if (q_item.cls.is_nul) begin
                                boot_next        = 1'b1;
                                phase_next       = PH_START;
                                res.event_res    = EV_MENU;
                                res.frame_length = 10'(wpos_inc);
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_START;
                    end
                endcase
                if (res.event_res == EV_FWD) begin
                    res.event_byte = b;
                end
            end
            KIND_TICK: begin
                if (phase_reg != PH_START) begin
                    if (ms_reg >= timeout_ms) begin
                        phase_next    = PH_START;
                        wpos_next     = '0;
                        res.event_res = EV_TIMEOUT;
                    end else begin
                        ms_next = ms_reg + 16'd1;
                    end
                end
            end
            KIND_READ: begin
                res.read_hit = (32'(q_item.read_index) < BUFFER_DEPTH);
                ram_re       = 1'b1;
            end
            KIND_DISC: begin
                res.home_id_changed = (hid_reg != '0);
                hid_next   = '0;
                have_next  = 1'b0;
                phase_next = PH_START;
                wpos_next  = '0;
                boot_next  = 1'b0;
            end
            KIND_RECONN: begin
                phase_next = PH_START;
                wpos_next  = '0;
                boot_next  = 1'b0;
            end
            default: begin
            end
        endcase

        res.home_id         = hid_next;
        res.home_id_ready   = have_next;
        res.bootloader_mode = boot_next;
    end

    sapfr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (exec && ram_we),
        .waddr (ram_waddr),
        .wdata (b),
        .re    (exec && ram_re),
        .raddr (AW'(q_item.read_index)),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START;
            wpos_reg    <= '0;
            endpos_reg  <= '0;
            xor_reg     <= XOR_INIT;
            boot_reg    <= 1'b0;
            hid_reg     <= '0;
            have_reg    <= 1'b0;
            ms_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (exec) begin
                phase_reg  <= phase_next;
                wpos_reg   <= wpos_next;
                endpos_reg <= endpos_next;
                xor_reg    <= xor_next;
                boot_reg   <= boot_next;
                hid_reg    <= hid_next;
                have_reg   <= have_next;
                ms_reg     <= ms_next;
            end
            if (exec) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result register, and a shadow of the header bytes so the home ID is taken without a store read.
    always_ff @(posedge aclk) begin
        if (exec) begin
            res_reg <= res;
        end
        for (int i = 1; i <= HDR_LAST; i++) begin
            if (exec && ram_we && ram_waddr == AW'(i)) begin
                hdr_reg[i] <= b;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_res       = res_reg;
    assign m_read_data = res_reg.read_hit ? ram_q : 8'h00;

endmodule

`default_nettype wire

// File: hw/rtl/serial_api_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// Serial API frame receiver
// Parses module bytes into frames, answers ACK or NAK and tracks the home ID.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Contents
//  --------  ---------  ------------------  ---------------------------------
//  s_*       in         s_valid / s_ready   action, rx_byte, read_index
//  m_*       out        m_valid / m_ready   tx, event, length, home ID, data
//  cfg_*     in         cfg_wr_en           frame timeout in milliseconds
//
//  The block takes one item per cycle and keeps that rate with both sides
//  flowing; an item passes the queue and the result register before its
//  result leaves. A two-entry queue between the decoder and the parser lets
//  a stalled result register hold the parser while the front accepts items
//  until the queue is full. The frame store is one RAM with one write and
//  one read port; each item uses at most one of them, which sets the
//  one-item-per-cycle figure. Reset is synchronous and needs no clearing
//  pass: the store and the data registers are undefined until written, and
//  every control bit clears at once.
`default_nettype none

`include "serial_api_frame_receiver_unit_assert.svh"

module serial_api_frame_receiver_unit
    import sapfr_pkg::*;
#(
    parameter int BUFFER_DEPTH = SAPFR_BUFFER_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_action,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic [8:0]  s_read_index,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_tx_valid,
    output logic [7:0]       m_tx_byte,
    output logic [2:0]       m_event_res,
    output logic [7:0]       m_event_byte,
    output logic [9:0]       m_frame_length,
    output logic [31:0]      m_home_id,
    output logic             m_home_id_changed,
    output logic             m_home_id_ready,
    output logic             m_bootloader_mode,
    output logic [7:0]       m_read_data
);

    // The user is to write the timeout register only while the block is idle; the block does not enforce this.
    logic [15:0]   timeout_reg;
    logic          q_valid, q_pop;
    sapfr_item_t   q_item;
    sapfr_result_t res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // Front end: decodes the action, classifies the byte and queues the item.
    sapfr_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_rx_byte    (s_rx_byte),
        .s_read_index (s_read_index),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_item       (q_item)
    );

    // Back end: the parser, the frame store and the result register.
    sapfr_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .timeout_ms  (timeout_reg),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_res       (res),
        .m_read_data (m_read_data)
    );

    assign m_tx_valid        = res.tx_valid;
    assign m_tx_byte         = res.tx_byte;
    assign m_event_res       = res.event_res;
    assign m_event_byte      = res.event_byte;
    assign m_frame_length    = res.frame_length;
    assign m_home_id         = res.home_id;
    assign m_home_id_changed = res.home_id_changed;
    assign m_home_id_ready   = res.home_id_ready;
    assign m_bootloader_mode = res.bootloader_mode;

    // A response byte is always ACK or NAK.
    `SAPFR_ASSERT_IMPL(a_tx_code, m_valid && m_tx_valid,
        m_tx_byte == ACK_BYTE || m_tx_byte == NAK_BYTE, "tx byte is not ACK or NAK")

    // An ACK only goes with a good frame of at least the minimum size.
    `SAPFR_ASSERT_IMPL(a_ack_frame, m_valid && m_tx_valid && m_tx_byte == ACK_BYTE,
        m_event_res == EV_FRAME && m_frame_length >= 10'd5, "ACK without a good frame")

    // Without a home ID response the stored identifier stays zero.
    `SAPFR_ASSERT_IMPL(a_hid_zero, m_valid && !m_home_id_ready,
        m_home_id == 32'd0, "home ID set while not ready")

    // An accepted item is waiting in the queue on the next cycle.
    `SAPFR_ASSERT_NEXT(a_queue_push, s_valid && s_ready, q_valid, "accepted item lost")

endmodule

`default_nettype wire
